### sv/ssf_pkg.sv
package ssf_pkg;

  // Sizing
  localparam int MAX_PATTERN = 16;
  localparam int MAX_SOURCE  = 65536;

  localparam int DATA_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int LEN_W   = 5;
  localparam int IDX_W   = 17;
  localparam int PIDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W   = $clog2(MAX_SOURCE + 2);
  localparam int START_W = $clog2(MAX_SOURCE);

  // APB register file
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_SOURCE  = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_PATTERN_LENGTH  = 1'b0,
    REG_SEARCH_FROM_END = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic             search_from_end;
  } cfg_t;

  // Common control for every cell of the window chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

### sv/ssf_apb.sv
module ssf_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssf_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssf_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output ssf_pkg::cfg_t                 cfg
);
  import ssf_pkg::*;

  reg_idx_t sel;
  logic     wr_en;

  assign sel    = reg_idx_t'(paddr[ADDR_W-1]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length  <= LEN_W'(1);
      cfg.search_from_end <= 1'b0;
    end else if (wr_en) begin
      unique case (sel)
        REG_PATTERN_LENGTH:  cfg.pattern_length  <= pwdata[LEN_W-1:0];
        REG_SEARCH_FROM_END: cfg.search_from_end <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      REG_PATTERN_LENGTH:  prdata = PDATA_W'(cfg.pattern_length);
      REG_SEARCH_FROM_END: prdata = PDATA_W'(cfg.search_from_end);
      default:             prdata = '0;
    endcase
  end

endmodule

### sv/ssf_cell.sv
module ssf_cell (
  input  logic                        clk,
  input  ssf_pkg::cell_ctl_t          ctl,
  input  logic [ssf_pkg::DATA_W-1:0]  shift_in,
  input  logic                        pat_we,
  input  logic [ssf_pkg::DATA_W-1:0]  pat_wdata,
  input  logic [ssf_pkg::DATA_W-1:0]  pat_sel,
  input  logic                        in_use,
  output logic [ssf_pkg::DATA_W-1:0]  win,
  output logic [ssf_pkg::DATA_W-1:0]  pat,
  output logic                        eq
);
  import ssf_pkg::*;

  // Window element: shifts in from the newer neighbor
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win <= '0;
    end else if (ctl.shift) begin
      win <= shift_in;
    end
  end

  // Pattern element for this slot
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat <= pat_wdata;
    end
  end

  // Compare the element arriving in this position with its pattern element
  assign eq = !in_use || (shift_in == pat_sel);

endmodule

### sv/substring_first_last_finder.sv
// Streaming substring search. Pattern elements are written by slot with
// req_type = 0; source elements follow with req_type = 1 and slide through a
// chain of MAX_PATTERN cells that compare the newest window against the
// first pattern_length pattern elements in parallel. The request carrying
// last_of_source returns one result: the start index of the first match (or
// the last one when search_from_end is set), -1 with status 0 if none, or
// -1 with status 1 on a length error. The block accepts one request per
// clock and stalls only while a finished result sits in the output register
// untaken. The registered result is valid the cycle after its last element.
// Configure pattern_length and search_from_end through APB while idle.
module substring_first_last_finder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssf_pkg::ADDR_W-1:0]          paddr,
  input  logic [ssf_pkg::PDATA_W-1:0]         pwdata,
  output logic [ssf_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [ssf_pkg::SLOT_W-1:0]          pattern_slot,
  input  logic [ssf_pkg::DATA_W-1:0]          value,
  input  logic                                last_of_source,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssf_pkg::IDX_W-1:0]    match_index,
  output logic                                status
);
  import ssf_pkg::*;

  cfg_t                cfg;
  cell_ctl_t           ctl;
  logic [DATA_W-1:0]   win     [MAX_PATTERN];
  logic [DATA_W-1:0]   pat     [MAX_PATTERN];
  logic [DATA_W-1:0]   pat_sel [MAX_PATTERN];
  logic [DATA_W-1:0]   chain_in[MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] use_mask;
  logic [MAX_PATTERN-1:0] pat_we;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                match_seen;
  logic                match_seen_next;
  logic [START_W-1:0]  match_start;
  logic [START_W-1:0]  match_start_next;

  logic in_fire;
  logic src_fire;
  logic pat_fire;
  logic active;
  logic len_ok;
  logic hit;
  logic len_err;
  logic [CNT_W-1:0] len_ext;

  // Configuration registers
  ssf_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign src_fire = in_fire && (req_type_t'(req_type) == REQ_SOURCE);
  assign pat_fire = in_fire && (req_type_t'(req_type) == REQ_PATTERN);

  // Stream count with saturation one past the source limit
  assign len_ext    = CNT_W'(cfg.pattern_length);
  assign count_next = (count <= CNT_W'(MAX_SOURCE)) ? count + CNT_W'(1) : count;
  assign active     = count_next <= CNT_W'(MAX_SOURCE);
  assign len_ok     = (cfg.pattern_length != '0) &&
                      (32'(cfg.pattern_length) <= MAX_PATTERN);

  assign ctl.shift = src_fire && active;
  assign ctl.clear = rst || (src_fire && last_of_source);

  // Window chain
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [PIDX_W-1:0] pidx;

    assign chain_in[j] = (j == 0) ? value : win[(j == 0) ? 0 : j - 1];
    assign pat_we[j]   = pat_fire && (32'(pattern_slot) == j);
    assign use_mask[j] = 32'(cfg.pattern_length) > j;
    // Window position j lines up with pattern slot pattern_length-1-j
    assign pidx        = PIDX_W'(32'(cfg.pattern_length) - 1 - j);
    assign pat_sel[j]  = pat[pidx];

    ssf_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (chain_in[j]),
      .pat_we    (pat_we[j]),
      .pat_wdata (value),
      .pat_sel   (pat_sel[j]),
      .in_use    (use_mask[j]),
      .win       (win[j]),
      .pat       (pat[j]),
      .eq        (eq[j])
    );
  end

  // Match tracking
  assign hit = src_fire && active && len_ok && (count_next >= len_ext) && (&eq);

  always_comb begin
    match_seen_next  = match_seen;
    match_start_next = match_start;
    if (hit && (cfg.search_from_end || !match_seen)) begin
      match_seen_next  = 1'b1;
      match_start_next = START_W'(count_next - len_ext);
    end
  end

  assign len_err = !len_ok || !active || (len_ext > count_next);

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
    end else if (src_fire) begin
      if (last_of_source) begin
        count       <= '0;
        match_seen  <= 1'b0;
        match_start <= '0;
      end else begin
        count       <= count_next;
        match_seen  <= match_seen_next;
        match_start <= match_start_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (src_fire && last_of_source) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire && last_of_source) begin
      status <= len_err;
      if (len_err || !match_seen_next) begin
        match_index <= '1;
      end else begin
        match_index <= IDX_W'(match_start_next);
      end
    end
  end

`ifndef SYNTH
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SOURCE + 1))
    else $error("source count past saturation");

  a_start_order: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (CNT_W'(match_start) < count))
    else $error("recorded match starts beyond the stream");

  a_unseen_zero: assert property (@(posedge clk) disable iff (rst)
    !match_seen |-> (match_start == '0))
    else $error("match start set without a match");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (src_fire && last_of_source) |=> (count == '0) && !match_seen && out_valid)
    else $error("stream state not cleared after result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted while result register blocked");
`endif

endmodule
